// File: rtl/core/windowed_position_speed_core_defines.svh
// ============================================================================
// windowed_position_speed_core_defines.svh
// Assertion macros shared by the windowed position speed checker.
// ============================================================================
`ifndef WINDOWED_POSITION_SPEED_CORE_DEFINES_SVH
`define WINDOWED_POSITION_SPEED_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define WPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define WPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wps_pkg.sv
// ============================================================================
// wps_pkg
// Types and fixed constants of the windowed position speed core.
// ============================================================================
`default_nettype none

package wps_pkg;

  localparam int POS_W      = 8;
  localparam int STAMP_W    = 32;
  localparam int SCALE_W    = 32;
  localparam int SPEED_W    = 8;
  localparam int WLEN_W     = 7;
  localparam int SQ_W       = 17;
  localparam int SQ_SHIFT   = 16;
  localparam int RAD_W      = SQ_W + SQ_SHIFT + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int PROD_W     = ROOT_W + SCALE_W;
  localparam int FRAC_LSB   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SPEED    = 3'd4;

  localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST  = 7'd30;
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 32'd65536;
  localparam logic [STAMP_W-1:0] MAX_GAP_RST     = 32'd1000000;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 8'd100;
  localparam logic [SPEED_W-1:0] FLAG_SPEED_RST  = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQX,
    ST_SQY,
    ST_ROOT_GO,
    ST_ROOT,
    ST_MD_GO,
    ST_MD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [STAMP_W-1:0] stamp;
  } hist_entry_t;

  typedef struct packed {
    logic                done;
    logic [ROOT_W-1:0]   root;
  } sqrt_sts_t;

  typedef struct packed {
    logic                start;
    logic [ROOT_W-1:0]   h;
    logic [SCALE_W-1:0]  scale;
    logic [STAMP_W-1:0]  dt;
  } md_req_t;

  typedef struct packed {
    logic                done;
    logic [PROD_W-1:0]   q;
  } md_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/wps_if.sv
// ============================================================================
// wps_if
// Valid/ready channels for position samples and speed results.
// ============================================================================
`default_nettype none

interface wps_in_if import wps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, output pos_x, output pos_y, output stamp, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input stamp, output ready);
endinterface

interface wps_out_if import wps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic               speed_valid;

  modport source (output valid, output speed, output speed_valid, input ready);
  modport sink   (input valid, input speed, input speed_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wps_history.sv
// ============================================================================
// wps_history
// Sample delay line: one write port, one registered read port.
// ============================================================================
`default_nettype none

module wps_history import wps_pkg::*; #(
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic        clk,
  input  logic        we,
  input  logic [AW-1:0] waddr,
  input  hist_entry_t wdata,
  input  logic        re,
  input  logic [AW-1:0] raddr,
  output hist_entry_t rdata_r
);

  hist_entry_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wps_isqrt.sv
// ============================================================================
// wps_isqrt
// Bit-serial integer square root of the squared distance shifted by 16,
// one root bit per cycle.
// ============================================================================
`default_nettype none

module wps_isqrt import wps_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] sq,
  output sqrt_sts_t       sts
);

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;
  localparam int TRY_W = REM_W + 3;

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [RAD_W-1:0]   rad_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [TRY_W-1:0]   try_c;
  logic               fit;
  logic               last;

  assign try_c = {1'b0, rem_r, rad_r[RAD_W-1 -: 2]} - TRY_W'({root_r, 2'b01});
  assign fit   = !try_c[TRY_W-1];
  assign last  = (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'({sq, {SQ_SHIFT{1'b0}}});
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (fit) begin
        rem_r  <= try_c[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign sts.done = done_r;
  assign sts.root = root_r;

endmodule

`default_nettype wire

// File: rtl/core/wps_muldiv.sv
// ============================================================================
// wps_muldiv
// Shift-add multiply of distance by scale, then restoring divide by the
// time span, one bit per cycle in a shared accumulator.
// ============================================================================
`default_nettype none

module wps_muldiv import wps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_sts_t sts
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  md_phase_t           phase_r;
  md_phase_t           phase_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;
  logic [PROD_W-1:0]   acc_r;
  logic [STAMP_W-1:0]  rem_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [STAMP_W-1:0]  dt_r;
  logic                last;
  logic [SCALE_W:0]    mul_sum;
  logic [STAMP_W:0]    div_try;
  logic [STAMP_W:0]    div_diff;
  logic                div_ge;

  assign last     = (cnt_r == CNT_W'(1));
  assign mul_sum  = {1'b0, acc_r[PROD_W-1 -: SCALE_W]} + (acc_r[0] ? {1'b0, scale_r} : '0);
  assign div_try  = {rem_r, acc_r[PROD_W-1]};
  assign div_diff = div_try - {1'b0, dt_r};
  assign div_ge   = (div_try >= {1'b0, dt_r});

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      MD_IDLE: begin
        if (req.start) phase_nxt = MD_MUL;
      end
      MD_MUL: begin
        if (last) phase_nxt = MD_DIV;
      end
      MD_DIV: begin
        if (last) phase_nxt = MD_IDLE;
      end
      default: phase_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == MD_DIV) && last;
      if ((phase_r == MD_IDLE) && req.start) begin
        cnt_r <= CNT_W'(ROOT_W);
      end else if ((phase_r == MD_MUL) && last) begin
        cnt_r <= CNT_W'(PROD_W);
      end else if (phase_r != MD_IDLE) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      MD_IDLE: begin
        if (req.start) begin
          acc_r   <= PROD_W'(req.h);
          scale_r <= req.scale;
          dt_r    <= req.dt;
        end
      end
      MD_MUL: begin
        acc_r <= {mul_sum, acc_r[ROOT_W-1:1]};
        rem_r <= '0;
      end
      MD_DIV: begin
        acc_r <= {acc_r[PROD_W-2:0], div_ge};
        rem_r <= div_ge ? div_diff[STAMP_W-1:0] : div_try[STAMP_W-1:0];
      end
      default: begin
        rem_r <= '0;
      end
    endcase
  end

  assign sts.done = done_r;
  assign sts.q    = acc_r;

endmodule

`default_nettype wire

// File: rtl/core/windowed_position_speed_core.sv
// ============================================================================
// windowed_position_speed_core
// Speed over a sliding window of position samples. Each accepted sample is
// compared with the one window_len samples earlier; the block returns
// round(hypot(dx,dy) * speed_scale / dt), speed_scale unsigned Q16.16, or
// flag_speed for a lost point, a zero or too long time span, or a speed
// above speed_limit. Until the window has filled, results carry
// speed_valid = 0 and speed 0. One sample is processed at a time: a full
// computation runs the 17-step square root, the 17-step multiply and the
// 49-step restoring divide, each one bit per cycle. Flagged samples skip
// them after the check and unfilled-window samples go straight to the done
// state, which waits for a free output register. A finished result waits
// in the output register while the next request is taken. Users must write
// configuration only while no sample is in work; the block does not check.
// ============================================================================
`default_nettype none

module windowed_position_speed_core import wps_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wps_in_if.sink                in_ch,
  wps_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (FW > WLEN_W) ? FW : WLEN_W;

  state_t               state_r;
  state_t               state_nxt;

  logic [WLEN_W-1:0]    window_len_r;
  logic [SCALE_W-1:0]   speed_scale_r;
  logic [STAMP_W-1:0]   max_gap_r;
  logic [SPEED_W-1:0]   speed_limit_r;
  logic [SPEED_W-1:0]   flag_speed_r;

  logic [AW-1:0]        ws_r;
  logic [AW-1:0]        ws_nxt;
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        fill_nxt;
  logic [CW-1:0]        wl_ext;
  logic [FW-1:0]        w_eff;
  logic [FW:0]          old_sum;
  logic [AW-1:0]        old_addr;
  logic                 item_ok;

  hist_entry_t          new_entry;
  hist_entry_t          old_entry;
  hist_entry_t          cur_r;

  logic [STAMP_W-1:0]   dt_r;
  logic [POS_W-1:0]     ax_r;
  logic [POS_W-1:0]     ay_r;
  logic                 lost_r;
  logic [SQ_W-1:0]      sq_r;
  logic [POS_W-1:0]     mul_in;
  logic [2*POS_W-1:0]   prod;
  logic                 flag_c;
  logic                 over_c;
  logic [SPEED_W-1:0]   rnd_c;
  logic [SPEED_W-1:0]   speed_r;
  logic                 res_valid_r;

  logic                 in_ready;
  logic                 in_accept;
  logic                 sqrt_start;
  logic                 out_load;
  sqrt_sts_t            sqrt_sts;
  md_req_t              md_req;
  md_sts_t              md_sts;

  logic                 out_valid_r;
  logic [SPEED_W-1:0]   out_speed_r;
  logic                 out_speed_valid_r;

  assign in_accept = in_ch.valid && in_ready;

  always_comb begin
    new_entry.x     = in_ch.pos_x;
    new_entry.y     = in_ch.pos_y;
    new_entry.stamp = in_ch.stamp;
  end

  // clamp the window and locate the compared slot
  always_comb begin
    wl_ext = CW'(window_len_r);
    if (wl_ext == '0) begin
      w_eff = FW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      w_eff = FW'(WINDOW_MAX);
    end else begin
      w_eff = FW'(wl_ext);
    end
    if (FW'(ws_r) >= w_eff) begin
      old_sum = (FW+1)'(FW'(ws_r) - w_eff);
    end else begin
      old_sum = (FW+1)'(ws_r) + (FW+1)'(WINDOW_MAX) - (FW+1)'(w_eff);
    end
    old_addr = old_sum[AW-1:0];
    item_ok  = (fill_r >= w_eff);
    ws_nxt   = (ws_r == AW'(WINDOW_MAX - 1)) ? '0 : ws_r + AW'(1);
    fill_nxt = (fill_r == FW'(WINDOW_MAX)) ? fill_r : fill_r + FW'(1);
  end

  wps_history #(
    .DEPTH (WINDOW_MAX)
  ) u_history (
    .clk     (clk),
    .we      (in_accept),
    .waddr   (ws_r),
    .wdata   (new_entry),
    .re      (in_accept),
    .raddr   (old_addr),
    .rdata_r (old_entry)
  );

  wps_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .sq    (sq_r),
    .sts   (sqrt_sts)
  );

  wps_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .sts   (md_sts)
  );

  assign mul_in = (state_r == ST_SQX) ? ax_r : ay_r;
  assign prod   = mul_in * mul_in;
  assign flag_c = lost_r || (dt_r == '0) || (dt_r > max_gap_r);
  assign over_c = md_sts.q > (PROD_W'(speed_limit_r) << FRAC_LSB);
  assign rnd_c  = md_sts.q[FRAC_LSB +: SPEED_W] + SPEED_W'(md_sts.q[FRAC_LSB-1]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = item_ok ? ST_CHECK : ST_DONE;
      end
      ST_CHECK:   state_nxt = ST_SQX;
      ST_SQX:     state_nxt = flag_c ? ST_DONE : ST_SQY;
      ST_SQY:     state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_sts.done) state_nxt = ST_MD_GO;
      end
      ST_MD_GO:   state_nxt = ST_MD;
      ST_MD: begin
        if (md_sts.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    sqrt_start   = (state_r == ST_ROOT_GO);
    md_req.start = (state_r == ST_MD_GO);
    md_req.h     = sqrt_sts.root;
    md_req.scale = speed_scale_r;
    md_req.dt    = dt_r;
    out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_len_r  <= WINDOW_LEN_RST;
      speed_scale_r <= SPEED_SCALE_RST;
      max_gap_r     <= MAX_GAP_RST;
      speed_limit_r <= SPEED_LIMIT_RST;
      flag_speed_r  <= FLAG_SPEED_RST;
      ws_r          <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WINDOW_LEN:    window_len_r  <= cfg_wdata[WLEN_W-1:0];
          CFG_SPEED_SCALE:   speed_scale_r <= cfg_wdata[SCALE_W-1:0];
          CFG_MAX_GAP_TICKS: max_gap_r     <= cfg_wdata[STAMP_W-1:0];
          CFG_SPEED_LIMIT:   speed_limit_r <= cfg_wdata[SPEED_W-1:0];
          CFG_FLAG_SPEED:    flag_speed_r  <= cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        ws_r   <= ws_nxt;
        fill_r <= fill_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r       <= new_entry;
      speed_r     <= '0;
      res_valid_r <= item_ok;
    end
    if (state_r == ST_CHECK) begin
      dt_r   <= cur_r.stamp - old_entry.stamp;
      ax_r   <= (old_entry.x >= cur_r.x) ? old_entry.x - cur_r.x : cur_r.x - old_entry.x;
      ay_r   <= (old_entry.y >= cur_r.y) ? old_entry.y - cur_r.y : cur_r.y - old_entry.y;
      lost_r <= ((old_entry.x == '0) && (old_entry.y == '0)) ||
                ((cur_r.x == '0) && (cur_r.y == '0));
    end
    if (state_r == ST_SQX) begin
      sq_r <= SQ_W'(prod);
      if (flag_c) speed_r <= flag_speed_r;
    end
    if (state_r == ST_SQY) begin
      sq_r <= sq_r + SQ_W'(prod);
    end
    if ((state_r == ST_MD) && md_sts.done) begin
      speed_r <= over_c ? flag_speed_r : rnd_c;
    end
    if (out_load) begin
      out_speed_r       <= speed_r;
      out_speed_valid_r <= res_valid_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.speed       = out_speed_r;
  assign out_ch.speed_valid = out_speed_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/wps_checker.sv
// ============================================================================
// wps_checker
// Port-level checks of the windowed position speed core, bound to the top.
// ============================================================================
`default_nettype none

`include "windowed_position_speed_core_defines.svh"

module wps_checker import wps_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [SPEED_W-1:0] out_speed,
  input wire logic               out_speed_valid
);

  `WPSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `WPSC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_speed) && $stable(out_speed_valid), "stalled result changed")

  `WPSC_ASSERT_NOW(a_unfilled_zero, out_valid && !out_speed_valid, out_speed == '0, "unfilled window gave nonzero speed")

  `WPSC_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "request taken while one is in work")

endmodule

bind windowed_position_speed_core wps_checker u_wps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_speed       (out_ch.speed),
  .out_speed_valid (out_ch.speed_valid)
);

`default_nettype wire
